/* design/gpab_pkg.sv */
// Shared types and constants for the glyph pixel alpha blend block.
`default_nettype none
package gpab_pkg;

  localparam int COORD_W    = 12;
  localparam int PIXEL_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_W      = 13;
  localparam int GLYPH_COLS = 8;
  localparam int GLYPH_ROWS = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Largest usable screen dimension; larger register values clamp to it
  localparam logic [DIM_W-1:0] SCREEN_DIM_MAX = 13'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLYPH_BITS    = 3'd0,
    REG_GLYPH_WIDTH   = 3'd1,
    REG_TEXT_SCALE    = 3'd2,
    REG_TEXT_COLOR    = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0]             glyph_bits;
    logic [3:0]              glyph_width;
    logic [3:0]              text_scale;
    logic [PIXEL_W-1:0]      text_color;
    logic signed [DIM_W-1:0] origin_x;
    logic signed [DIM_W-1:0] origin_y;
    logic [DIM_W-1:0]        screen_width;
    logic [DIM_W-1:0]        screen_height;
  } cfg_t;

  // One classified pixel waiting for the blend unit
  typedef struct packed {
    logic               hit;
    logic [PIXEL_W-1:0] bg;
  } q_entry_t;

endpackage
`default_nettype wire

/* design/gpab_if.sv */
// Stream interfaces for pixels in and blended pixels out.
`default_nettype none
interface gpab_pix_if;
  logic                         valid;
  logic                         ready;
  logic [gpab_pkg::COORD_W-1:0] pixel_x;
  logic [gpab_pkg::COORD_W-1:0] pixel_y;
  logic [gpab_pkg::PIXEL_W-1:0] background_pixel;
  modport source(output valid, pixel_x, pixel_y, background_pixel, input ready);
  modport sink(input valid, pixel_x, pixel_y, background_pixel, output ready);
endinterface

interface gpab_res_if;
  logic                         valid;
  logic                         ready;
  logic [gpab_pkg::PIXEL_W-1:0] pixel_out;
  logic                         pixel_changed;
  modport source(output valid, pixel_out, pixel_changed, input ready);
  modport sink(input valid, pixel_out, pixel_changed, output ready);
endinterface
`default_nettype wire

/* design/gpab_front.sv */
// Front end: box and screen test, glyph cell lookup, push to queue.
`default_nettype none
module gpab_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire gpab_pkg::cfg_t  cfg,
  gpab_pix_if.sink             pix_in,
  input  wire logic            q_full,
  output logic                 q_push,
  output gpab_pkg::q_entry_t   q_data
);
  import gpab_pkg::*;

  logic                 en;
  logic [3:0]           w_sat;
  logic [3:0]           s_sat;
  logic [DIM_W-1:0]     sw_sat;
  logic [DIM_W-1:0]     sh_sat;
  logic [7:0]           box_w;
  logic [6:0]           box_h;
  logic signed [DIM_W:0] dx;
  logic signed [DIM_W:0] dy;
  logic                 in_box;

  logic                 s1_valid;
  logic                 s1_inside;
  logic [6:0]           s1_dx;
  logic [6:0]           s1_dy;
  logic [PIXEL_W-1:0]   s1_bg;
  logic                 s2_valid;
  q_entry_t             s2_entry;

  logic [2:0]           col;
  logic [2:0]           row;
  logic [5:0]           idx;

  // Whole front advances unless the queue refuses the finished item
  assign en = !(s2_valid && q_full);
  assign pix_in.ready = en;

  // Clamp configuration to its usable range
  assign w_sat  = (cfg.glyph_width > 4'd8) ? 4'd8 : cfg.glyph_width;
  assign s_sat  = (cfg.text_scale == 4'd0) ? 4'd1 : cfg.text_scale;
  assign sw_sat = (cfg.screen_width > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : cfg.screen_width;
  assign sh_sat = (cfg.screen_height > SCREEN_DIM_MAX) ? SCREEN_DIM_MAX : cfg.screen_height;
  assign box_w  = w_sat * s_sat;
  assign box_h  = {s_sat, 3'b000};

  // Offset from glyph origin and inside test
  assign dx = $signed({2'b00, pix_in.pixel_x}) - $signed({cfg.origin_x[DIM_W-1], cfg.origin_x});
  assign dy = $signed({2'b00, pix_in.pixel_y}) - $signed({cfg.origin_y[DIM_W-1], cfg.origin_y});
  assign in_box = ({1'b0, pix_in.pixel_x} < sw_sat) && ({1'b0, pix_in.pixel_y} < sh_sat)
                  && !dx[DIM_W] && !dy[DIM_W]
                  && (dx[DIM_W-1:0] < {5'd0, box_w})
                  && (dy[DIM_W-1:0] < {6'd0, box_h});

  // Cell index: count the scale multiples at or below each offset
  always_comb begin
    col = 3'd0;
    row = 3'd0;
    for (int k = 1; k < GLYPH_COLS; k++) begin
      if (s1_dx >= 7'(k * s_sat)) col = col + 3'd1;
      if (s1_dy >= 7'(k * s_sat)) row = row + 3'd1;
    end
    idx = {row, col};
  end

  // Advance the two front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pix_in.valid;
      s2_valid <= s1_valid;
    end
    if (en) begin
      s1_inside    <= in_box;
      s1_dx        <= dx[6:0];
      s1_dy        <= dy[6:0];
      s1_bg        <= pix_in.background_pixel;
      s2_entry.hit <= s1_inside && cfg.glyph_bits[idx];
      s2_entry.bg  <= s1_bg;
    end
  end

  assign q_push = s2_valid && !q_full;
  assign q_data = s2_entry;

endmodule
`default_nettype wire

/* design/gpab_queue.sv */
// Short queue between the classifier and the blend unit.
`default_nettype none
module gpab_queue #(
  parameter int DEPTH = gpab_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire gpab_pkg::q_entry_t wr_data,
  input  wire logic               pop,
  output gpab_pkg::q_entry_t      rd_data,
  output logic                    full,
  output logic                    empty
);
  import gpab_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/gpab_back.sv */
// Back end: per-channel alpha blend and output register.
`default_nettype none
module gpab_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [gpab_pkg::PIXEL_W-1:0] text_color,
  input  wire gpab_pkg::q_entry_t q_data,
  input  wire logic               q_empty,
  output logic                    q_pop,
  gpab_res_if.source              pix_out
);
  import gpab_pkg::*;

  logic               en;
  logic [7:0]         alpha;
  logic [7:0]         alpha_inv;
  logic               m_valid;
  logic               m_hit;
  logic [PIXEL_W-1:0] m_bg;
  logic [15:0]        m_sum [3];
  logic [7:0]         chan  [3];
  logic               o_valid;
  logic [PIXEL_W-1:0] o_pixel;
  logic               o_changed;

  assign en        = !o_valid || pix_out.ready;
  assign q_pop     = en && !q_empty;
  assign alpha     = text_color[31:24];
  assign alpha_inv = 8'd255 - alpha;

  // Divide each weighted sum by 255 exactly for sums up to 255*255, the largest a blend gives
  always_comb begin
    logic [15:0] t;
    for (int c = 0; c < 3; c++) begin
      t = m_sum[c] + 16'd1 + {8'd0, m_sum[c][15:8]};
      chan[c] = t[15:8];
    end
  end

  // Multiply stage, then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      m_valid <= !q_empty;
      o_valid <= m_valid;
    end
    if (en) begin
      m_hit <= q_data.hit;
      m_bg  <= q_data.bg;
      for (int c = 0; c < 3; c++) begin
        m_sum[c] <= text_color[8*c +: 8] * alpha + alpha_inv * q_data.bg[8*c +: 8];
      end
      o_changed <= m_hit;
      o_pixel   <= m_hit ? {m_bg[31:24], chan[2], chan[1], chan[0]} : m_bg;
    end
  end

  assign pix_out.valid         = o_valid;
  assign pix_out.pixel_out     = o_pixel;
  assign pix_out.pixel_changed = o_changed;

endmodule
`default_nettype wire

/* design/glyph_pixel_alpha_blend.sv */
// Text overlay stage: blends one configured 8x8 glyph over a pixel stream.
//
// pix_in carries one screen pixel per transfer (pixel_x, pixel_y,
// background_pixel); pix_out returns one result per pixel, in order, with
// pixel_out and pixel_changed. Both use valid/ready; a transfer happens on
// a rising clk edge with both high.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while no pixel is in flight.
// Throughput: one pixel per cycle sustained while pix_out is ready. From input
// transfer to output valid a pixel passes two classify stages, queue write,
// multiply and the output register.
// Reset (rst, synchronous) empties the pipeline and queue and loads the
// register defaults: blank glyph, width 8, scale 1, opaque white, origin 0,
// 640x480 screen.
// When pix_out stalls, the blend unit holds and the queue between classifier
// and blend unit fills; pix_in.ready drops only once the queue is full.
`default_nettype none
module glyph_pixel_alpha_blend #(
  parameter int QUEUE_DEPTH = gpab_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gpab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gpab_pkg::CFG_DATA_W-1:0] cfg_data,
  gpab_pix_if.sink                             pix_in,
  gpab_res_if.source                           pix_out
);
  import gpab_pkg::*;

  cfg_t     cfg;
  q_entry_t q_wr;
  q_entry_t q_rd;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_bits    <= '0;
      cfg.glyph_width   <= 4'd8;
      cfg.text_scale    <= 4'd1;
      cfg.text_color    <= 32'hFFFF_FFFF;
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.screen_width  <= 13'd640;
      cfg.screen_height <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GLYPH_BITS:    cfg.glyph_bits    <= cfg_data;
        REG_GLYPH_WIDTH:   cfg.glyph_width   <= cfg_data[3:0];
        REG_TEXT_SCALE:    cfg.text_scale    <= cfg_data[3:0];
        REG_TEXT_COLOR:    cfg.text_color    <= cfg_data[PIXEL_W-1:0];
        REG_ORIGIN_X:      cfg.origin_x      <= cfg_data[DIM_W-1:0];
        REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data[DIM_W-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  gpab_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix_in (pix_in),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  gpab_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  gpab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (cfg.text_color),
    .q_data     (q_rd),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pix_out    (pix_out)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty)) else $error("queue pop while empty");
  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !pix_out.valid) else $error("output valid after reset");
  // Input is refused only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> q_full) else $error("input stalled with queue space");

endmodule
`default_nettype wire

/* verif/glyph_pixel_alpha_blend_tb.sv */
// Testbench for the glyph pixel alpha blend stage: directed and random pixels.
`timescale 1ns / 1ps
module glyph_pixel_alpha_blend_tb;
  import gpab_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gpab_pix_if pix_in();
  gpab_res_if pix_out();

  glyph_pixel_alpha_blend i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic               changed;
  } blend_result_t;

  // Shadow copy of the configuration registers
  logic [63:0]       sh_glyph;
  logic [3:0]        sh_width;
  logic [3:0]        sh_scale;
  logic [31:0]       sh_color;
  logic signed [12:0] sh_org_x;
  logic signed [12:0] sh_org_y;
  logic [12:0]       sh_scr_w;
  logic [12:0]       sh_scr_h;

  blend_result_t pending_pixels[$];
  int  error_count;
  int  send_idle_pct;
  int  recv_idle_pct;
  longint cycle_count;

  localparam longint CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a runaway run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[glyph_pixel_alpha_blend] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] mix_channel(logic [7:0] top, logic [7:0] alpha,
                                             logic [7:0] bottom);
    logic [16:0] sum;
    sum = top * alpha + (8'd255 - alpha) * bottom;
    return 8'(sum / 255);
  endfunction

  // Predict the overlay of one pixel under the shadow configuration
  function automatic blend_result_t overlay_pixel(logic [11:0] px, logic [11:0] py,
                                                  logic [31:0] bg);
    blend_result_t res;
    int w, s, sw, sh, dx, dy, idx;
    logic hit;
    w  = (sh_width > 8) ? 8 : sh_width;
    s  = (sh_scale == 0) ? 1 : sh_scale;
    sw = (sh_scr_w > 4096) ? 4096 : sh_scr_w;
    sh = (sh_scr_h > 4096) ? 4096 : sh_scr_h;
    dx = int'(px) - int'(sh_org_x);
    dy = int'(py) - int'(sh_org_y);
    hit = 1'b0;
    if (px < sw && py < sh && dx >= 0 && dy >= 0 && dx < w * s && dy < 8 * s) begin
      idx = ((dx / s) + 8 * (dy / s)) & 63;
      hit = sh_glyph[idx];
    end
    if (hit) begin
      res.pixel = {bg[31:24], mix_channel(sh_color[23:16], sh_color[31:24], bg[23:16]),
                   mix_channel(sh_color[15:8], sh_color[31:24], bg[15:8]),
                   mix_channel(sh_color[7:0], sh_color[31:24], bg[7:0])};
      res.changed = 1'b1;
    end else begin
      res.pixel = bg;
      res.changed = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Compare every output transfer with the oldest prediction
  always @(posedge clk) begin
    blend_result_t exp_res;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result", pix_out.pixel_out, 0);
      end else begin
        exp_res = pending_pixels.pop_front();
        if (pix_out.pixel_out !== exp_res.pixel)
          report_mismatch("pixel_out", pix_out.pixel_out, exp_res.pixel);
        if (pix_out.pixel_changed !== exp_res.changed)
          report_mismatch("pixel_changed", pix_out.pixel_changed, exp_res.changed);
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    pix_in.valid <= 1'b0;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GLYPH_BITS:    sh_glyph = value;
      REG_GLYPH_WIDTH:   sh_width = value[3:0];
      REG_TEXT_SCALE:    sh_scale = value[3:0];
      REG_TEXT_COLOR:    sh_color = value[31:0];
      REG_ORIGIN_X:      sh_org_x = value[12:0];
      REG_ORIGIN_Y:      sh_org_y = value[12:0];
      REG_SCREEN_WIDTH:  sh_scr_w = value[12:0];
      REG_SCREEN_HEIGHT: sh_scr_h = value[12:0];
      default: ;
    endcase
  endtask

  // Drive one pixel and hold it until the transfer; valid stays up for the next one
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [31:0] bg);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid            <= 1'b1;
    pix_in.pixel_x          <= px;
    pix_in.pixel_y          <= py;
    pix_in.background_pixel <= bg;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pending_pixels.push_back(overlay_pixel(px, py, bg));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Pixels near the glyph box with a random offset; now and then a coordinate is drawn at random
  task automatic send_near_box();
    int px, py;
    px = int'(sh_org_x) + $urandom_range(130) - 5;
    py = int'(sh_org_y) + $urandom_range(130) - 5;
    if ($urandom_range(9) == 0) px = $urandom_range(4095);
    if ($urandom_range(9) == 0) py = $urandom_range(4095);
    send_pixel(12'(px), 12'(py), $urandom);
  endtask

  task automatic test_defaults();
    send_pixel(12'd0, 12'd0, 32'h1234_5678);
    wait_drained();
    write_reg(REG_GLYPH_BITS, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'd7, 12'd7, 32'hFFFF_FFFF);
    send_pixel(12'd8, 12'd0, 32'hA5A5_A5A5);
    send_pixel(12'd4095, 12'd4095, 32'h5A5A_5A5A);
    wait_drained();
  endtask

  task automatic test_corners();
    // Wide glyph, zero scale, large screen
    write_reg(REG_GLYPH_BITS, 64'h8000_0000_0000_0081);
    write_reg(REG_GLYPH_WIDTH, 64'd15);
    write_reg(REG_TEXT_SCALE, 64'd0);
    write_reg(REG_TEXT_COLOR, 64'h80FF_0000);
    write_reg(REG_ORIGIN_X, 64'h1F00);
    write_reg(REG_ORIGIN_Y, 64'h0FFF);
    write_reg(REG_SCREEN_WIDTH, 64'h1FFF);
    write_reg(REG_SCREEN_HEIGHT, 64'h1FFF);
    send_pixel(12'd0, 12'd4095, 32'hFF00_FF00);
    send_pixel(12'd7, 12'd4095, 32'h0000_0000);
    wait_drained();
    write_reg(REG_ORIGIN_X, 64'd4088);
    write_reg(REG_ORIGIN_Y, 64'd4088);
    send_pixel(12'd4095, 12'd4095, 32'h1122_3344);
    send_pixel(12'd4088, 12'd4088, 32'h1122_3344);
    wait_drained();
    // Zero width and empty screen pass all pixels
    write_reg(REG_ORIGIN_X, 64'd0);
    write_reg(REG_ORIGIN_Y, 64'd0);
    write_reg(REG_GLYPH_WIDTH, 64'd0);
    send_pixel(12'd0, 12'd0, 32'hDEAD_BEEF);
    wait_drained();
    write_reg(REG_GLYPH_WIDTH, 64'd8);
    write_reg(REG_SCREEN_WIDTH, 64'd0);
    send_pixel(12'd0, 12'd0, 32'hDEAD_BEEF);
    wait_drained();
    write_reg(REG_SCREEN_WIDTH, 64'd4096);
    write_reg(REG_SCREEN_HEIGHT, 64'd0);
    send_pixel(12'd0, 12'd0, 32'hDEAD_BEEF);
    wait_drained();
    write_reg(REG_SCREEN_HEIGHT, 64'd4096);
    write_reg(REG_TEXT_SCALE, 64'd15);
    write_reg(REG_TEXT_COLOR, 64'h00FF_FFFF);
    send_pixel(12'd119, 12'd119, 32'h0102_0304);
    wait_drained();
    write_reg(REG_TEXT_COLOR, 64'h0000_0000);
    send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Random configurations with pixels clustered around the glyph
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(REG_GLYPH_BITS, {$urandom, $urandom});
      write_reg(REG_GLYPH_WIDTH, $urandom_range(15));
      write_reg(REG_TEXT_SCALE, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                         : $urandom_range(4));
      write_reg(REG_TEXT_COLOR, $urandom);
      write_reg(REG_ORIGIN_X, ($urandom_range(3) == 0) ? $urandom : $urandom_range(200));
      write_reg(REG_ORIGIN_Y, ($urandom_range(3) == 0) ? $urandom : $urandom_range(200));
      write_reg(REG_SCREEN_WIDTH, ($urandom_range(4) == 0) ? $urandom : 4096 - $urandom_range(10));
      write_reg(REG_SCREEN_HEIGHT, ($urandom_range(4) == 0) ? $urandom : 4096 - $urandom_range(10));
      for (int i = 0; i < per_phase; i++) begin
        send_near_box();
        // Hold off until the pipeline is empty once per phase
        if (i == per_phase / 2) begin
          pix_in.valid <= 1'b0;
          while (pending_pixels.size() != 0) @(negedge clk);
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pix_in.valid = 1'b0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    pix_in.background_pixel = '0;
    pix_out.ready = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    send_idle_pct = 27;
    recv_idle_pct = 47;
    sh_glyph = '0;
    sh_width = 4'd8;
    sh_scale = 4'd1;
    sh_color = 32'hFFFF_FFFF;
    sh_org_x = '0;
    sh_org_y = '0;
    sh_scr_w = 13'd640;
    sh_scr_h = 13'd480;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_corners();
    test_random(8, 80);
    send_idle_pct = 47;
    recv_idle_pct = 27;
    test_random(8, 80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(8, 80);

    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("[glyph_pixel_alpha_blend] OK");
    end else begin
      $display("[glyph_pixel_alpha_blend] ERROR");
    end
    $finish;
  end
endmodule
